[rtl/pdc_pkg.sv]
// Shared types and constants for the pellet dispenser controller.
// No dependencies; imported by pdc_req_queue and pellet_dispenser_controller.
package pdc_pkg;

    // Default depth of the pending request queue.
    localparam int QUEUE_DEPTH_DEF = 4;

    // Stream payload widths, padded to whole bytes.
    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 32;

    // Configuration port.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_TOGGLE_THRESHOLD = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_SLOT_RATIO   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_REVERSALS    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_COOLDOWN_US      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SELF_CHECK_US    = 3'd4;

    // Register reset values.
    localparam logic [14:0] TOGGLE_THRESHOLD_RST = 15'd1000;
    localparam logic [7:0]  MAX_SLOT_RATIO_RST   = 8'd4;
    localparam logic [7:0]  MAX_REVERSALS_RST    = 8'd3;
    localparam logic [31:0] COOLDOWN_US_RST      = 32'd1000000;
    localparam logic [31:0] SELF_CHECK_US_RST    = 32'd60000000;

    // Width of one queued request (pellets wanted).
    localparam int REQ_W = 8;

    // Done status codes.
    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_EMPTY  = 2'd1;
    localparam logic [1:0] STATUS_JAMMED = 2'd2;

    // Reject codes.
    localparam logic REJECT_UNHEALTHY  = 1'b0;
    localparam logic REJECT_QUEUE_FULL = 1'b1;

    // Queue control from the mode logic.
    typedef struct packed {
        logic push;
        logic pop;
    } queue_ctrl_t;

endpackage

[rtl/pdc_req_queue.sv]
// Shift-style request queue for the pellet dispenser controller.
// Depends on pdc_pkg for the request width and the control struct.
module pdc_req_queue #(
    parameter int QUEUE_DEPTH = pdc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  pdc_pkg::queue_ctrl_t               ctrl,
    input  logic [pdc_pkg::REQ_W-1:0]          push_data,
    output logic [pdc_pkg::REQ_W-1:0]          head,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]   fill,
    output logic                               full
);
    import pdc_pkg::*;

    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    logic [REQ_W-1:0]  entry_reg [QUEUE_DEPTH];
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic [FILL_W-1:0] wr_pos;
    logic [IDX_W-1:0]  wr_idx;
    logic              wr_en;

    // A push onto an empty queue that is popped in the same tick bypasses storage.
    assign head = (fill_reg == '0) ? push_data : entry_reg[0];
    assign fill = fill_reg;
    assign full = (fill_reg == FILL_W'(QUEUE_DEPTH));

    always_comb
    begin
        wr_pos    = ctrl.pop ? (fill_reg - FILL_W'(1)) : fill_reg;
        wr_idx    = wr_pos[IDX_W-1:0];
        wr_en     = ctrl.push && !(ctrl.pop && (fill_reg == '0));
        fill_next = fill_reg + FILL_W'(ctrl.push) - FILL_W'(ctrl.pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.pop)
        begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++)
            begin
                entry_reg[i] <= entry_reg[i+1];
            end
        end
        if (wr_en)
        begin
            entry_reg[wr_idx] <= push_data;
        end
    end

endmodule

[rtl/pellet_dispenser_controller.sv]
// Pellet dispenser controller: top level with stream ports, configuration and mode logic.
// Depends on pdc_pkg and pdc_req_queue.
// A tick request is taken into the input register; once the result register is free, its
// result is registered there and offered on the output stream. One tick per cycle is
// sustained while m_axis_tready stays high, with the mode update computed combinationally
// between the input register and the result register. A result that is not taken holds
// the result register; the input register takes one more request and then s_axis_tready
// drops until the result leaves.
// Reset (rst_n, asynchronous, active low) puts the block in self-check with both sensors on,
// the counter off, an empty queue and the configuration registers at their defaults.
module pellet_dispenser_controller #(
    parameter int QUEUE_DEPTH = pdc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Input ticks. s_axis_tdata from bit 0 up: now_us[47:0], wheel_sensor_value,
    // wheel_sensor_error, pellet_sensor_value, pellet_sensor_error, slot_passed,
    // wheel_position[15:0], count_valid, pellet_total[15:0], motor_fault,
    // request_valid, request_count[7:0].
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [pdc_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // Results. m_axis_tdata from bit 0 up: reject_valid, reject_code, done_valid,
    // done_count[15:0], done_status[1:0], motor_run, motor_reverse, pellet_sensor_on,
    // wheel_sensor_on, counter_on, mode_now[1:0], healthy, then three zero bits.
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [pdc_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // Configuration writes.
    input  logic                               cfg_wr_en,
    input  logic [pdc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [pdc_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import pdc_pkg::*;

    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        MODE_CHECK = 2'd0,
        MODE_IDLE  = 2'd1,
        MODE_DISP  = 2'd2
    } mode_t;

    // ------------------------------------------------------------------
    // Configuration registers. Writes are to be made only while the block is idle;
    // the block does not enforce this and takes them with no pipeline interlock.
    // ------------------------------------------------------------------
    logic [14:0] toggle_threshold_reg;
    logic [7:0]  max_slot_ratio_reg;
    logic [7:0]  max_reversals_reg;
    logic [31:0] cooldown_us_reg;
    logic [31:0] self_check_us_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            toggle_threshold_reg <= TOGGLE_THRESHOLD_RST;
            max_slot_ratio_reg   <= MAX_SLOT_RATIO_RST;
            max_reversals_reg    <= MAX_REVERSALS_RST;
            cooldown_us_reg      <= COOLDOWN_US_RST;
            self_check_us_reg    <= SELF_CHECK_US_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_TOGGLE_THRESHOLD: toggle_threshold_reg <= cfg_data[14:0];
                CFG_MAX_SLOT_RATIO:   max_slot_ratio_reg   <= cfg_data[7:0];
                CFG_MAX_REVERSALS:    max_reversals_reg    <= cfg_data[7:0];
                CFG_COOLDOWN_US:      cooldown_us_reg      <= cfg_data;
                CFG_SELF_CHECK_US:    self_check_us_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake. The input register holds one tick request; the result
    // register holds one result. A new request is taken whenever the input
    // register is empty or is moving into the result register this cycle,
    // so a waiting result stops the input side only once the input
    // register is also full.
    // ------------------------------------------------------------------
    logic                 in_valid_reg;
    logic [IN_DATA_W-1:0] in_data_reg;
    logic                 out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic                 out_free;
    logic                 advance;
    logic                 in_accept;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // ------------------------------------------------------------------
    // Field unpacking of the registered tick.
    // ------------------------------------------------------------------
    logic [47:0]        now_us;
    logic               wheel_sensor_value;
    logic               wheel_sensor_error;
    logic               pellet_sensor_value;
    logic               pellet_sensor_error;
    logic               slot_passed;
    logic signed [15:0] wheel_position;
    logic               count_valid;
    logic [15:0]        pellet_total;
    logic               motor_fault;
    logic               request_valid;
    logic [7:0]         request_count;

    assign now_us              = in_data_reg[47:0];
    assign wheel_sensor_value  = in_data_reg[48];
    assign wheel_sensor_error  = in_data_reg[49];
    assign pellet_sensor_value = in_data_reg[50];
    assign pellet_sensor_error = in_data_reg[51];
    assign slot_passed         = in_data_reg[52];
    assign wheel_position      = in_data_reg[68:53];
    assign count_valid         = in_data_reg[69];
    assign pellet_total        = in_data_reg[85:70];
    assign motor_fault         = in_data_reg[86];
    assign request_valid       = in_data_reg[87];
    assign request_count       = in_data_reg[95:88];

    // ------------------------------------------------------------------
    // Controller state.
    // tested_good: bit 0 pellet tested, bit 1 wheel tested,
    // bit 2 pellet good, bit 3 wheel good.
    // ------------------------------------------------------------------
    mode_t       mode_reg,           mode_next;
    logic        sane_reg,           sane_next;
    logic [3:0]  tested_good_reg,    tested_good_next;
    logic [47:0] idle_start_reg,     idle_start_next;
    logic        report_pending_reg, report_pending_next;
    logic [1:0]  report_status_reg,  report_status_next;
    logic [15:0] start_count_reg,    start_count_next;
    logic [7:0]  wanted_count_reg,   wanted_count_next;
    logic [15:0] slots_reg,          slots_next;
    logic [7:0]  reversal_count_reg, reversal_count_next;
    logic        current_reverse_reg, current_reverse_next;
    logic        saved_reverse_reg,  saved_reverse_next;
    logic        pellet_on_reg,      pellet_on_next;
    logic        wheel_on_reg,       wheel_on_next;
    logic        counter_on_reg,     counter_on_next;

    // Request queue.
    queue_ctrl_t       q_ctrl;
    logic [REQ_W-1:0]  q_head;
    logic [FILL_W-1:0] q_fill;
    logic              q_full;

    pdc_req_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_req_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (q_ctrl),
        .push_data (request_count),
        .head      (q_head),
        .fill      (q_fill),
        .full      (q_full)
    );

    // Per-tick results.
    logic        reject_valid;
    logic        reject_code;
    logic        done_valid;
    logic [15:0] done_count;
    logic [1:0]  done_status;

    // Helper terms.
    logic               push_ok;
    logic [FILL_W-1:0]  fill_after_push;
    logic               idle_started;
    logic [47:0]        idle_elapsed;
    logic               cooldown_hit;
    logic               period_hit;
    logic [15:0]        count_diff;
    logic [15:0]        empty_limit;
    logic signed [16:0] pos_ext;
    logic signed [16:0] pos_neg;
    logic signed [16:0] thr_ext;
    logic               dir_reverse;

    always_comb
    begin
        // The request is handled first, so a request taken now can start now.
        push_ok         = request_valid && sane_reg && !q_full;
        reject_valid    = request_valid && !(sane_reg && !q_full);
        reject_code     = reject_valid && sane_reg ? REJECT_QUEUE_FULL : REJECT_UNHEALTHY;
        fill_after_push = q_fill + FILL_W'(push_ok);

        idle_started = (now_us >= idle_start_reg);
        idle_elapsed = now_us - idle_start_reg;
        cooldown_hit = idle_started && (idle_elapsed >= {16'd0, cooldown_us_reg});
        period_hit   = idle_started && (idle_elapsed >= {16'd0, self_check_us_reg});
        count_diff   = pellet_total - start_count_reg;
        empty_limit  = max_slot_ratio_reg * wanted_count_reg;

        pos_ext     = {wheel_position[15], wheel_position};
        pos_neg     = -pos_ext;
        thr_ext     = {2'b00, toggle_threshold_reg};
        dir_reverse = saved_reverse_reg;

        q_ctrl.push = push_ok;
        q_ctrl.pop  = 1'b0;

        done_valid  = 1'b0;
        done_count  = '0;
        done_status = STATUS_OK;

        mode_next            = mode_reg;
        sane_next            = sane_reg;
        tested_good_next     = tested_good_reg;
        idle_start_next      = idle_start_reg;
        report_pending_next  = report_pending_reg;
        report_status_next   = report_status_reg;
        start_count_next     = start_count_reg;
        wanted_count_next    = wanted_count_reg;
        slots_next           = slots_reg;
        reversal_count_next  = reversal_count_reg;
        current_reverse_next = current_reverse_reg;
        saved_reverse_next   = saved_reverse_reg;
        pellet_on_next       = pellet_on_reg;
        wheel_on_next        = wheel_on_reg;
        counter_on_next      = counter_on_reg;

        unique case (mode_reg)
            MODE_CHECK:
            begin
                // Each sensor is marked tested on its first reading or error, then
                // switched off.
                if (pellet_on_reg && (pellet_sensor_value || pellet_sensor_error))
                begin
                    tested_good_next[0] = 1'b1;
                    tested_good_next[2] = !pellet_sensor_error;
                    pellet_on_next      = 1'b0;
                end
                if (wheel_on_reg && (wheel_sensor_value || wheel_sensor_error))
                begin
                    tested_good_next[1] = 1'b1;
                    tested_good_next[3] = !wheel_sensor_error;
                    wheel_on_next       = 1'b0;
                end
                if (tested_good_next[1:0] == 2'b11)
                begin
                    sane_next           = tested_good_next[2] && tested_good_next[3];
                    mode_next           = MODE_IDLE;
                    idle_start_next     = now_us;
                    report_pending_next = 1'b0;
                    report_status_next  = STATUS_OK;
                end
            end
            MODE_IDLE:
            begin
                // A pending report goes out at most once: on cooldown expiry or
                // when idle is left, whichever comes first.
                if (cooldown_hit)
                begin
                    counter_on_next = 1'b0;
                end
                if ((cooldown_hit || period_hit || (fill_after_push != '0))
                    && report_pending_reg)
                begin
                    done_valid          = 1'b1;
                    done_count          = count_diff;
                    done_status         = report_status_reg;
                    report_pending_next = 1'b0;
                end
                if (period_hit)
                begin
                    mode_next        = MODE_CHECK;
                    tested_good_next = '0;
                    pellet_on_next   = 1'b1;
                    wheel_on_next    = 1'b1;
                end
                else if (fill_after_push != '0)
                begin
                    q_ctrl.pop = 1'b1;
                    // Direction flips when the wheel has drifted to or past the threshold
                    // in the current direction.
                    if (!saved_reverse_reg && (pos_ext >= thr_ext))
                    begin
                        dir_reverse = 1'b1;
                    end
                    else if (saved_reverse_reg && (pos_neg >= thr_ext))
                    begin
                        dir_reverse = 1'b0;
                    end
                    saved_reverse_next   = dir_reverse;
                    current_reverse_next = dir_reverse;
                    wanted_count_next    = q_head;
                    start_count_next     = pellet_total;
                    slots_next           = '0;
                    reversal_count_next  = '0;
                    pellet_on_next       = 1'b1;
                    counter_on_next      = 1'b1;
                    mode_next            = MODE_DISP;
                end
            end
            MODE_DISP:
            begin
                if (slot_passed && (slots_reg != 16'hFFFF))
                begin
                    slots_next = slots_reg + 16'd1;
                end
                if (count_valid && (count_diff >= {8'd0, wanted_count_reg}))
                begin
                    saved_reverse_next  = current_reverse_reg;
                    mode_next           = MODE_IDLE;
                    idle_start_next     = now_us;
                    report_pending_next = 1'b1;
                    report_status_next  = STATUS_OK;
                end
                else if (slots_next >= empty_limit)
                begin
                    saved_reverse_next  = current_reverse_reg;
                    mode_next           = MODE_IDLE;
                    idle_start_next     = now_us;
                    report_pending_next = 1'b1;
                    report_status_next  = STATUS_EMPTY;
                end
                else if (motor_fault)
                begin
                    if (reversal_count_reg >= max_reversals_reg)
                    begin
                        saved_reverse_next  = current_reverse_reg;
                        mode_next           = MODE_IDLE;
                        idle_start_next     = now_us;
                        report_pending_next = 1'b1;
                        report_status_next  = STATUS_JAMMED;
                    end
                    else
                    begin
                        current_reverse_next = !current_reverse_reg;
                        reversal_count_next  = reversal_count_reg + 8'd1;
                    end
                end
            end
            default:
            begin
                mode_next = MODE_CHECK;
            end
        endcase

        if (!advance)
        begin
            q_ctrl.push = 1'b0;
            q_ctrl.pop  = 1'b0;
        end
    end

    // Result word for the tick being committed.
    logic [OUT_DATA_W-1:0] result_word;
    logic                  motor_run;

    always_comb
    begin
        motor_run   = (mode_next == MODE_DISP);
        result_word = {3'b000,
                       sane_next,
                       mode_next,
                       counter_on_next,
                       wheel_on_next,
                       pellet_on_next,
                       motor_run && current_reverse_next,
                       motor_run,
                       done_status,
                       done_count,
                       done_valid,
                       reject_code,
                       reject_valid};
    end

    // ------------------------------------------------------------------
    // State, handshake and result registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
            mode_reg            <= MODE_CHECK;
            sane_reg            <= 1'b0;
            tested_good_reg     <= '0;
            idle_start_reg      <= '0;
            report_pending_reg  <= 1'b0;
            report_status_reg   <= STATUS_OK;
            start_count_reg     <= '0;
            wanted_count_reg    <= '0;
            slots_reg           <= '0;
            reversal_count_reg  <= '0;
            current_reverse_reg <= 1'b0;
            saved_reverse_reg   <= 1'b0;
            pellet_on_reg       <= 1'b1;
            wheel_on_reg        <= 1'b1;
            counter_on_reg      <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                mode_reg            <= mode_next;
                sane_reg            <= sane_next;
                tested_good_reg     <= tested_good_next;
                idle_start_reg      <= idle_start_next;
                report_pending_reg  <= report_pending_next;
                report_status_reg   <= report_status_next;
                start_count_reg     <= start_count_next;
                wanted_count_reg    <= wanted_count_next;
                slots_reg           <= slots_next;
                reversal_count_reg  <= reversal_count_next;
                current_reverse_reg <= current_reverse_next;
                saved_reverse_reg   <= saved_reverse_next;
                pellet_on_reg       <= pellet_on_next;
                wheel_on_reg        <= wheel_on_next;
                counter_on_reg      <= counter_on_next;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_data_reg <= s_axis_tdata;
        end
        if (advance)
        begin
            out_data_reg <= result_word;
        end
    end

endmodule
